// ----- hdl/naive_bayes_text_classifier_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the naive Bayes classifier core
// Shared property wrappers; the using module provides i_clk and i_rst_n.
// ----------------------------------------------------------------------------
`ifndef NAIVE_BAYES_TEXT_CLASSIFIER_CORE_DEFINES_SVH
`define NAIVE_BAYES_TEXT_CLASSIFIER_CORE_DEFINES_SVH

// same-cycle implication
`define NBTC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NBTC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/nbtc_pkg.sv -----
// ----------------------------------------------------------------------------
// nbtc_pkg
// Constants, codes and controller/datapath interface types of the classifier.
// ----------------------------------------------------------------------------
package nbtc_pkg;

    localparam int MAX_LABELS = 8;
    localparam int LBL_W      = $clog2(MAX_LABELS);
    localparam int MAX_TERMS  = 4096;
    localparam int TERM_W     = 12;
    localparam int COUNT_BITS = 16;
    localparam int ROW_W      = MAX_LABELS * COUNT_BITS;
    localparam int LOG_W      = 22;
    localparam int LOGIN_W    = 33;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [15:0]           DOC_MAX = 16'hFFFF;
    localparam logic [31:0]           TOT_MAX = 32'hFFFF_FFFF;
    localparam logic signed [31:0]    SCORE_FLOOR = 32'sh8000_0000;
    localparam logic signed [31:0]    SCORE_CEIL  = 32'sh7FFF_FFFF;

    // item kinds
    localparam logic [2:0] K_TRAIN  = 3'd0;
    localparam logic [2:0] K_DOC    = 3'd1;
    localparam logic [2:0] K_CTERM  = 3'd2;
    localparam logic [2:0] K_FINISH = 3'd3;
    localparam logic [2:0] K_CLEAR  = 3'd4;

    // register indexes
    localparam logic CFG_VOCAB  = 1'b0;
    localparam logic CFG_LABELS = 1'b1;

    // log unit operand select
    localparam logic [1:0] LOG_NUM = 2'd0;
    localparam logic [1:0] LOG_DEN = 2'd1;
    localparam logic [1:0] LOG_DOC = 2'd2;

    typedef struct packed {
        logic       capture;
        logic       clr_step;
        logic       tab_clear;
        logic       train_wr;
        logic       doc_inc;
        logic       lbl_clr;
        logic       lbl_inc;
        logic       log_start;
        logic [1:0] log_sel;
        logic       keep_num;
        logic       score_upd;
        logic       fin_init;
        logic       fin_upd;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [2:0] kind;
        logic       label_ok;
        logic       clr_last;
        logic       lbl_last;
        logic       fin_skip;
        logic       log_done;
        logic       log_busy;
        logic       out_free;
    } t_stat;

    // saturate a 34-bit signed sum to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'(SCORE_CEIL)) begin
            r = SCORE_CEIL;
        end else if (v < 34'(SCORE_FLOOR)) begin
            r = SCORE_FLOOR;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- hdl/nbtc_ram.sv -----
// ----------------------------------------------------------------------------
// nbtc_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nbtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write, then read registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- hdl/nbtc_log2.sv -----
// ----------------------------------------------------------------------------
// nbtc_log2
// Iterative fixed-point log2: six normalising steps, sixteen squaring rounds.
// ----------------------------------------------------------------------------
module nbtc_log2 import nbtc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [LOGIN_W-1:0] i_x,
    output logic               o_busy,
    output logic               o_done,
    output logic [LOG_W-1:0]   o_y
);

    logic        r_busy, r_norm, r_done;
    logic [63:0] r_x, n_x;
    logic [5:0]  r_s, n_s, r_e;
    logic [2:0]  r_step;
    logic [31:0] r_m;
    logic [15:0] r_frac;
    logic [3:0]  r_cnt;
    logic [6:0]  w_k;
    logic [63:0] w_p;

    // one normalising step: shift left by k when the top k bits are clear
    always_comb begin
        w_k = 7'd32 >> r_step;
        n_x = r_x;
        n_s = r_s;
        if ((r_x >> (7'd64 - w_k)) == 64'd0) begin
            n_x = r_x << w_k;
            n_s = r_s + w_k[5:0];
        end
    end

    assign w_p = 64'(r_m) * 64'(r_m);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && !r_norm && r_cnt == 4'd15) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= {31'd0, (i_x == '0) ? 33'd1 : i_x};
            r_s    <= '0;
            r_step <= '0;
            r_norm <= 1'b1;
            r_cnt  <= '0;
            r_frac <= '0;
        end else if (r_busy && r_norm) begin
            r_x    <= n_x;
            r_s    <= n_s;
            r_step <= r_step + 3'd1;
            if (r_step == 3'd5) begin
                r_norm <= 1'b0;
                r_m    <= n_x[63:32];
                r_e    <= 6'd63 - n_s;
            end
        end else if (r_busy) begin
            r_cnt  <= r_cnt + 4'd1;
            r_frac <= {r_frac[14:0], w_p[63]};
            r_m    <= w_p[63] ? w_p[63:32] : w_p[62:31];
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_y    = {r_e, r_frac};

endmodule

// ----- hdl/nbtc_ctrl.sv -----
// ----------------------------------------------------------------------------
// nbtc_ctrl
// Sequencer: clearing pass, item dispatch and per-label loops.
// ----------------------------------------------------------------------------
module nbtc_ctrl import nbtc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_st,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_TWR   = 4'd3;
    localparam logic [3:0] S_CNUM  = 4'd4;
    localparam logic [3:0] S_WNUM  = 4'd5;
    localparam logic [3:0] S_CDEN  = 4'd6;
    localparam logic [3:0] S_WDEN  = 4'd7;
    localparam logic [3:0] S_FCHK  = 4'd8;
    localparam logic [3:0] S_FWAIT = 4'd9;
    localparam logic [3:0] S_FOUT  = 4'd10;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_st.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_IDLE;
                unique case (i_st.kind)
                    K_TRAIN:  if (i_st.label_ok) n_state = S_TWR;
                    K_DOC:    o_cmd.doc_inc = 1'b1;
                    K_CTERM: begin
                        o_cmd.lbl_clr = 1'b1;
                        n_state = S_CNUM;
                    end
                    K_FINISH: begin
                        o_cmd.lbl_clr  = 1'b1;
                        o_cmd.fin_init = 1'b1;
                        n_state = S_FCHK;
                    end
                    K_CLEAR: begin
                        o_cmd.tab_clear = 1'b1;
                        n_state = S_CLR;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_TWR: begin
                o_cmd.train_wr = 1'b1;
                n_state = S_IDLE;
            end
            S_CNUM: begin
                o_cmd.log_start = 1'b1;
                o_cmd.log_sel   = LOG_NUM;
                n_state = S_WNUM;
            end
            S_WNUM: begin
                if (i_st.log_done) begin
                    o_cmd.keep_num = 1'b1;
                    n_state = S_CDEN;
                end
            end
            S_CDEN: begin
                o_cmd.log_start = 1'b1;
                o_cmd.log_sel   = LOG_DEN;
                n_state = S_WDEN;
            end
            S_WDEN: begin
                if (i_st.log_done) begin
                    o_cmd.score_upd = 1'b1;
                    if (i_st.lbl_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.lbl_inc = 1'b1;
                        n_state = S_CNUM;
                    end
                end
            end
            S_FCHK: begin
                if (i_st.fin_skip) begin
                    if (i_st.lbl_last) n_state = S_FOUT;
                    else o_cmd.lbl_inc = 1'b1;
                end else begin
                    o_cmd.log_start = 1'b1;
                    o_cmd.log_sel   = LOG_DOC;
                    n_state = S_FWAIT;
                end
            end
            S_FWAIT: begin
                if (i_st.log_done) begin
                    o_cmd.fin_upd = 1'b1;
                    if (i_st.lbl_last) begin
                        n_state = S_FOUT;
                    end else begin
                        o_cmd.lbl_inc = 1'b1;
                        n_state = S_FCHK;
                    end
                end
            end
            S_FOUT: begin
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

endmodule

// ----- hdl/nbtc_dp.sv -----
// ----------------------------------------------------------------------------
// nbtc_dp
// Datapath: count RAM, label tables, log unit, scores and result register.
// ----------------------------------------------------------------------------
module nbtc_dp import nbtc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_st,
    input  logic [2:0]          i_kind,
    input  logic [3:0]          i_label,
    input  logic [TERM_W-1:0]   i_term,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [12:0]         i_cfg_data,
    input  logic                i_ready,
    output logic                o_valid,
    output logic [3:0]          o_best_label,
    output logic signed [31:0]  o_best_score,
    output logic                o_no_label
);

    logic [2:0]        r_kind;
    logic [3:0]        r_label;
    logic [TERM_W-1:0] r_term;
    logic [12:0]       r_vocab;
    logic [3:0]        r_use_cfg, w_use;
    logic [TERM_W-1:0] r_clr_addr;
    logic [LBL_W-1:0]  r_lbl, w_idx, w_k;
    logic              w_label_ok;

    logic [31:0]        r_total [MAX_LABELS];
    logic [15:0]        r_doc   [MAX_LABELS];
    logic signed [31:0] r_score [MAX_LABELS];
    logic [31:0]        w_total;
    logic [15:0]        w_doc;
    logic signed [31:0] w_score;

    logic [ROW_W-1:0]      w_rdata, w_wdata;
    logic                  w_we;
    logic [TERM_W-1:0]     w_waddr;
    logic [COUNT_BITS-1:0] w_lane;

    logic [LOGIN_W-1:0] w_logx;
    logic               w_log_busy, w_log_done;
    logic [LOG_W-1:0]   w_logy, r_lognum;

    logic signed [31:0] w_upd, w_fin, r_best;
    logic [3:0]         r_best_l;
    logic               r_any;

    // capture item
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_label <= i_label;
            r_term  <= i_term;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vocab   <= 13'd4096;
            r_use_cfg <= 4'(MAX_LABELS);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VOCAB:  r_vocab   <= i_cfg_data;
                CFG_LABELS: r_use_cfg <= i_cfg_data[3:0];
                default:    r_vocab   <= r_vocab;
            endcase
        end
    end

    assign w_use      = (r_use_cfg > 4'(MAX_LABELS)) ? 4'(MAX_LABELS) : r_use_cfg;
    assign w_label_ok = (r_label != 4'd0) && (r_label <= 4'(MAX_LABELS));
    assign w_k        = LBL_W'(r_label - 4'd1);
    assign w_idx      = (i_cmd.train_wr || i_cmd.doc_inc) ? w_k : r_lbl;
    assign w_total    = r_total[w_idx];
    assign w_doc      = r_doc[w_idx];
    assign w_score    = r_score[w_idx];

    // label counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.lbl_clr) begin
            r_lbl <= '0;
        end else if (i_cmd.lbl_inc) begin
            r_lbl <= r_lbl + LBL_W'(1);
        end
    end

    // clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.tab_clear) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + TERM_W'(1);
        end
    end

    // count row: one lane per label, saturating increment on train
    assign w_lane = w_rdata[r_lbl*COUNT_BITS +: COUNT_BITS];
    always_comb begin
        w_wdata = '0;
        if (!i_cmd.clr_step) begin
            for (int l = 0; l < MAX_LABELS; l++) begin
                w_wdata[l*COUNT_BITS +: COUNT_BITS] = w_rdata[l*COUNT_BITS +: COUNT_BITS];
                if (LBL_W'(l) == w_k &&
                    w_rdata[l*COUNT_BITS +: COUNT_BITS] != CNT_MAX) begin
                    w_wdata[l*COUNT_BITS +: COUNT_BITS] =
                        w_rdata[l*COUNT_BITS +: COUNT_BITS] + COUNT_BITS'(1);
                end
            end
        end
    end
    assign w_we    = i_cmd.clr_step || i_cmd.train_wr;
    assign w_waddr = i_cmd.clr_step ? r_clr_addr : r_term;

    nbtc_ram #(.WIDTH(ROW_W), .DEPTH(MAX_TERMS)) u_counts (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_term),
        .o_rdata (w_rdata)
    );

    // log operand select
    always_comb begin
        unique case (i_cmd.log_sel)
            LOG_NUM: w_logx = LOGIN_W'(w_lane) + LOGIN_W'(1);
            LOG_DEN: w_logx = LOGIN_W'(w_total) + LOGIN_W'(r_vocab);
            LOG_DOC: w_logx = LOGIN_W'(w_doc);
            default: w_logx = '0;
        endcase
    end

    nbtc_log2 u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.log_start),
        .i_x     (w_logx),
        .o_busy  (w_log_busy),
        .o_done  (w_log_done),
        .o_y     (w_logy)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.keep_num) r_lognum <= w_logy;
    end

    // score arithmetic
    assign w_upd = sat32(34'(w_score) + $signed({12'd0, r_lognum}) - $signed({12'd0, w_logy}));
    assign w_fin = sat32(34'(w_score) + $signed({12'd0, w_logy}));

    // label tables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.tab_clear) begin
            for (int l = 0; l < MAX_LABELS; l++) begin
                r_total[l] <= '0;
                r_doc[l]   <= '0;
                r_score[l] <= '0;
            end
        end else if (i_cmd.out_load) begin
            for (int l = 0; l < MAX_LABELS; l++) r_score[l] <= '0;
        end else begin
            if (i_cmd.train_wr && w_total != TOT_MAX) r_total[w_idx] <= w_total + 32'd1;
            if (i_cmd.doc_inc && w_label_ok && w_doc != DOC_MAX) begin
                r_doc[w_idx] <= w_doc + 16'd1;
            end
            if (i_cmd.score_upd) r_score[w_idx] <= w_upd;
        end
    end

    // running best
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_init) begin
            r_best   <= SCORE_FLOOR;
            r_best_l <= '0;
            r_any    <= 1'b0;
        end else if (i_cmd.fin_upd) begin
            r_any <= 1'b1;
            if (w_fin > r_best) begin
                r_best   <= w_fin;
                r_best_l <= 4'(r_lbl) + 4'd1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_best_label <= r_best_l;
            o_best_score <= r_best;
            o_no_label   <= !r_any;
        end
    end

    assign o_st.kind     = r_kind;
    assign o_st.label_ok = w_label_ok;
    assign o_st.clr_last = (r_clr_addr == '1);
    assign o_st.lbl_last = (r_lbl == LBL_W'(MAX_LABELS - 1));
    assign o_st.fin_skip = !(4'(r_lbl) < w_use) || (w_doc == 16'd0);
    assign o_st.log_done = w_log_done;
    assign o_st.log_busy = w_log_busy;
    assign o_st.out_free = !o_valid || i_ready;

endmodule

// ----- hdl/naive_bayes_text_classifier_core.sv -----
// Train term and document count pass through dispatch; clear adds a clearing pass.
// Classify term: two log2 evaluations per label, all eight labels, on one log unit.
// Finish: one log2 per used label with documents; output waits for a free result register.
// Log unit: 6 normalising steps then 16 squaring rounds on one 32x32 multiplier.
// Synchronous active-low reset clears tables and starts the 4096-row clearing
// pass of the count RAM; no item is taken until it ends, config writes still are.
// ----------------------------------------------------------------------------
// naive_bayes_text_classifier_core
// Multinomial naive Bayes text classifier, log2 fixed point, top level.
// ----------------------------------------------------------------------------
`include "naive_bayes_text_classifier_core_defines.svh"

module naive_bayes_text_classifier_core import nbtc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [2:0]          i_kind,
    input  logic [3:0]          i_label,
    input  logic [TERM_W-1:0]   i_term,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [3:0]          o_best_label,
    output logic signed [31:0]  o_best_score,
    output logic                o_no_label,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [12:0]         i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_st;

    nbtc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_st    (w_st),
        .o_cmd   (w_cmd)
    );

    nbtc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_st         (w_st),
        .i_kind       (i_kind),
        .i_label      (i_label),
        .i_term       (i_term),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_best_label (o_best_label),
        .o_best_score (o_best_score),
        .o_no_label   (o_no_label)
    );

    // checks
    `NBTC_ASSERT_IMP(a_ready_log_idle, o_ready, !w_st.log_busy, "input ready while log unit busy")
    `NBTC_ASSERT_IMP(a_load_free, w_cmd.out_load, w_st.out_free, "result loaded over pending beat")
    `NBTC_ASSERT_NXT(a_log_runs, w_cmd.log_start, w_st.log_busy, "log unit did not start")

endmodule

// ----- tb/tb_naive_bayes_text_classifier_core.sv -----
// ----------------------------------------------------------------------------
// Testbench for the naive Bayes text classifier core
// Drives training, document, classify, finish and clear beats with random idling on
// both channels. A scoreboard class predicts each finish result in the log2
// fixed-point domain and checks every output beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_naive_bayes_text_classifier_core;
    import nbtc_pkg::*;

    // kinds outside the defined set; the core must ignore them
    localparam logic [2:0] K_SPARE_5 = 3'd5;
    localparam logic [2:0] K_SPARE_7 = 3'd7;
    localparam int CYCLE_LIMIT = 6000000;
    localparam int SETTLE      = 5000;

    typedef struct {
        logic [3:0]         best_label;
        logic signed [31:0] best_score;
        logic               no_label;
    } t_verdict;

    // ------------------------------------------------------------------
    // Scoreboard: classifier predictor plus queue of expected verdicts
    // ------------------------------------------------------------------
    class nb_scoreboard;
        logic [15:0]        term_cnt [MAX_LABELS*MAX_TERMS];
        logic [31:0]        word_total [MAX_LABELS];
        logic [15:0]        doc_cnt [MAX_LABELS];
        logic signed [31:0] run_score [MAX_LABELS];
        logic [12:0]        vocab;
        logic [3:0]         labels_used;
        t_verdict           verdicts [$];
        int                 errors;

        function new();
            errors      = 0;
            vocab       = 13'd4096;
            labels_used = 4'd8;
            wipe();
        endfunction

        function void wipe();
            foreach (term_cnt[i]) term_cnt[i] = '0;
            foreach (word_total[i]) begin
                word_total[i] = '0;
                doc_cnt[i]    = '0;
                run_score[i]  = '0;
            end
        endfunction

        function void set_reg(logic idx, logic [12:0] val);
            if (idx == CFG_VOCAB) vocab = val;
            else labels_used = val[3:0];
        endfunction

        function int pending();
            return verdicts.size();
        endfunction

        // log2 with 16 fraction bits by repeated squaring
        function longint log2_q16(longint unsigned x);
            int e;
            longint unsigned m, frac;
            e = 0;
            frac = 0;
            if (x == 0) x = 1;
            while (e < 63 && (x >> (e + 1)) != 0) e++;
            if (e > 31) m = x >> (e - 31);
            else m = x << (31 - e);
            for (int i = 0; i < 16; i++) begin
                m = (m * m) >> 31;
                frac = frac << 1;
                if (m >= 64'h1_0000_0000) begin
                    frac = frac | 1;
                    m = m >> 1;
                end
            end
            return (longint'(e) << 16) + longint'(frac);
        endfunction

        function logic signed [31:0] clip32(longint v);
            if (v > 64'sd2147483647) return SCORE_CEIL;
            if (v < -64'sd2147483648) return SCORE_FLOOR;
            return v[31:0];
        endfunction

        // advance the predicted state on one accepted input beat
        function void note_input(logic [2:0] kind, logic [3:0] label, logic [11:0] term);
            int k, use_n;
            longint num, den, best_s;
            logic signed [31:0] s;
            t_verdict v;
            bit any;
            case (kind)
                K_TRAIN: begin
                    if (label != 0 && label <= MAX_LABELS) begin
                        k = label - 1;
                        if (term_cnt[k*MAX_TERMS+term] != CNT_MAX)
                            term_cnt[k*MAX_TERMS+term]++;
                        if (word_total[k] != TOT_MAX) word_total[k]++;
                    end
                end
                K_DOC: begin
                    if (label != 0 && label <= MAX_LABELS && doc_cnt[label-1] != DOC_MAX)
                        doc_cnt[label-1]++;
                end
                K_CTERM: begin
                    for (int l = 0; l < MAX_LABELS; l++) begin
                        num = longint'(term_cnt[l*MAX_TERMS+term]) + 1;
                        den = longint'(word_total[l]) + longint'(vocab);
                        run_score[l] = clip32(longint'(run_score[l]) + log2_q16(num)
                                              - log2_q16(den));
                    end
                end
                K_FINISH: begin
                    use_n  = (labels_used > MAX_LABELS) ? MAX_LABELS : labels_used;
                    best_s = -64'sd2147483648;
                    v.best_label = 4'd0;
                    any = 0;
                    for (int l = 0; l < use_n; l++) begin
                        if (doc_cnt[l] != 0) begin
                            any = 1;
                            s = clip32(longint'(run_score[l]) + log2_q16(doc_cnt[l]));
                            if (longint'(s) > best_s) begin
                                best_s = s;
                                v.best_label = 4'(l + 1);
                            end
                        end
                    end
                    foreach (run_score[i]) run_score[i] = '0;
                    v.best_score = best_s[31:0];
                    v.no_label   = !any;
                    verdicts.insert(verdicts.size(), v);
                end
                K_CLEAR: wipe();
                default: ;
            endcase
        endfunction

        // compare one output beat with the oldest expected verdict
        function void check_result(logic [3:0] lbl, logic signed [31:0] score, logic nl);
            t_verdict v;
            if (verdicts.size() == 0) begin
                $display("%0t: unexpected result label %0d score %0d no_label %0d",
                         $time, lbl, score, nl);
                errors++;
                return;
            end
            v = verdicts.pop_front();
            if (lbl !== v.best_label) begin
                $display("%0t: best_label expected %0d actual %0d", $time, v.best_label, lbl);
                errors++;
            end
            if (score !== v.best_score) begin
                $display("%0t: best_score expected %0d actual %0d", $time, v.best_score, score);
                errors++;
            end
            if (nl !== v.no_label) begin
                $display("%0t: no_label expected %0d actual %0d", $time, v.no_label, nl);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [2:0]         i_kind;
    logic [3:0]         i_label;
    logic [TERM_W-1:0]  i_term;
    logic               o_valid;
    logic               i_ready;
    logic [3:0]         o_best_label;
    logic signed [31:0] o_best_score;
    logic               o_no_label;
    logic               i_cfg_we;
    logic               i_cfg_idx;
    logic [12:0]        i_cfg_data;

    nb_scoreboard sb;
    bit           calm;      // suppress idling on both sides
    int           cycles;

    naive_bayes_text_classifier_core dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // guard against a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: check each beat, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) sb.check_result(o_best_label, o_best_score, o_no_label);
            i_ready <= calm ? 1'b1 : ($urandom_range(99) >= 37);
        end
    end

    // present one beat and hold it until accepted
    task automatic send(logic [2:0] kind, logic [3:0] label, logic [11:0] term);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(99) < 37) gap = $urandom_range(1, 6);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind  <= kind;
        i_label <= label;
        i_term  <= term;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(kind, label, term);
    endtask

    // drop valid and wait out every pending verdict plus any clearing pass
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // one register write, after which the enable returns low
    task automatic write_reg(logic idx, logic [12:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    // one random beat, mostly coherent training and classification traffic
    task automatic random_beat();
        int r;
        logic [11:0] t;
        r = $urandom_range(99);
        t = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(15));
        if (r < 42)      send(K_TRAIN, 4'($urandom_range(1, 8)), t);
        else if (r < 55) send(K_DOC, 4'($urandom_range(1, 8)), 12'($urandom));
        else if (r < 83) send(K_CTERM, 4'($urandom), t);
        else if (r < 93) send(K_FINISH, 4'($urandom), 12'($urandom));
        else if (r < 94) send(K_CLEAR, 4'($urandom), 12'($urandom));
        else if (r < 97) send(K_TRAIN, ($urandom_range(1) ? 4'd0 : 4'($urandom_range(9, 15))),
                              12'($urandom));
        else             send(3'($urandom_range(K_SPARE_5, K_SPARE_7)), 4'($urandom),
                              12'($urandom));
    endtask

    initial begin
        logic [12:0] vocab_set [5] = '{13'd1, 13'd4096, 13'd8191, 13'd37, 13'd0};
        logic [12:0] lbl_set [5]   = '{13'd1, 13'd8, 13'd15, 13'd3, 13'd0};
        sb         = new();
        calm       = 0;
        cycles     = 0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_kind     = '0;
        i_label    = '0;
        i_term     = '0;
        i_ready    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_VOCAB;
        i_cfg_data = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty finish, field extremes, ignored labels and kinds
        send(K_FINISH, 4'd0, 12'd0);
        send(K_TRAIN, 4'd1, 12'd0);
        send(K_TRAIN, 4'd8, 12'hFFF);
        send(K_TRAIN, 4'd0, 12'd5);
        send(K_TRAIN, 4'd9, 12'd5);
        send(K_TRAIN, 4'd15, 12'hFFF);
        send(K_DOC, 4'd0, 12'd0);
        send(K_DOC, 4'd15, 12'd0);
        send(K_DOC, 4'd1, 12'd0);
        send(K_DOC, 4'd8, 12'hFFF);
        send(K_DOC, 4'd8, 12'd0);
        send(K_CTERM, 4'd0, 12'd0);
        send(K_CTERM, 4'd15, 12'hFFF);
        send(K_FINISH, 4'd0, 12'd0);
        send(K_SPARE_5, 4'd1, 12'd1);
        send(3'd6, 4'd1, 12'd1);
        send(K_SPARE_7, 4'hF, 12'hFFF);
        send(K_FINISH, 4'hF, 12'hFFF);
        drain();
        write_reg(CFG_VOCAB, 13'd0);
        write_reg(CFG_LABELS, 13'd15);
        send(K_CLEAR, 4'd0, 12'd0);
        send(K_DOC, 4'd2, 12'd0);
        send(K_CTERM, 4'd0, 12'd3);
        send(K_FINISH, 4'd0, 12'd0);
        drain();
        write_reg(CFG_LABELS, 13'd0);
        send(K_FINISH, 4'd0, 12'd0);
        drain();

        // random phases, each under its own register setting
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(CFG_VOCAB, vocab_set[ph]);
            write_reg(CFG_LABELS, lbl_set[ph]);
            for (int n = 0; n < 400; n++) begin
                calm = (ph == 2 && n >= 100 && n < 300);
                random_beat();
            end
            calm = 0;
            drain();
        end
        write_reg(CFG_VOCAB, 13'd4096);
        write_reg(CFG_LABELS, 13'd8);
        for (int n = 0; n < 100; n++) random_beat();
        i_valid <= 1'b0;

        // hold for outstanding verdicts, then a short settle
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (1000) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
